// ===== rtl/core/v2fa_pkg.sv =====
`timescale 1ns / 1ps
package v2fa_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COORD_WIDTH-1:0] VAL_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] VAL_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    // -1.0 in fixed point
    localparam logic [COORD_WIDTH-1:0] NEG_ONE_FIX =
        ~(COORD_WIDTH'(1) << FRAC_BITS) + COORD_WIDTH'(1);

    // code 7 is unused and gives an all-zero result
    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_DIV   = 3'd2,
        KIND_SCALE = 3'd3,
        KIND_LERP  = 3'd4,
        KIND_DIST  = 3'd5,
        KIND_NORM  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0]                    kind;
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] scalar;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] result_x;
        logic signed [COORD_WIDTH-1:0] result_y;
        logic                          degenerate;
        logic                          overflow;
    } rsp_t;

    // classified item, front to back
    typedef struct packed {
        kind_t                         op;
        logic signed [COORD_WIDTH:0]   opnd_x;
        logic signed [COORD_WIDTH:0]   opnd_y;
        logic signed [COORD_WIDTH-1:0] base_x;
        logic signed [COORD_WIDTH-1:0] base_y;
        logic signed [COORD_WIDTH-1:0] scalar;
        logic                          deg;
    } job_t;

    typedef struct packed {
        logic                  full;
        logic [QCNT_WIDTH-1:0] count;
    } qstat_t;

endpackage

// ===== rtl/core/v2fa_front.sv =====
`timescale 1ns / 1ps
module v2fa_front (
    input  v2fa_pkg::cmd_t   cmd,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  v2fa_pkg::qstat_t q_stat,
    output logic             push,
    output v2fa_pkg::job_t   job
);

    localparam int W = v2fa_pkg::COORD_WIDTH;

    v2fa_pkg::kind_t op;
    logic signed [W:0] ax;
    logic signed [W:0] ay;
    logic signed [W:0] bx;
    logic signed [W:0] by;
    logic signed [W:0] sum_x;
    logic signed [W:0] sum_y;
    logic signed [W:0] dif_x;
    logic signed [W:0] dif_y;

    assign cmd_stall = q_stat.full;
    assign push      = cmd_valid && !q_stat.full;

    always_comb
    begin
        op    = v2fa_pkg::kind_t'(cmd.kind);
        ax    = {cmd.a_x[W-1], cmd.a_x};
        ay    = {cmd.a_y[W-1], cmd.a_y};
        bx    = {cmd.b_x[W-1], cmd.b_x};
        by    = {cmd.b_y[W-1], cmd.b_y};
        sum_x = ax + bx;
        sum_y = ay + by;
        dif_x = bx - ax;
        dif_y = by - ay;

        job.op     = op;
        job.opnd_x = ax;
        job.opnd_y = ay;
        job.base_x = cmd.a_x;
        job.base_y = cmd.a_y;
        job.scalar = cmd.scalar;
        job.deg    = 1'b0;
        case (op)
            v2fa_pkg::KIND_ADD:
            begin
                job.opnd_x = sum_x;
                job.opnd_y = sum_y;
            end
            v2fa_pkg::KIND_SUB, v2fa_pkg::KIND_LERP:
            begin
                job.opnd_x = dif_x;
                job.opnd_y = dif_y;
            end
            v2fa_pkg::KIND_DIST:
            begin
                job.opnd_x = dif_x;
                job.opnd_y = dif_y;
                job.deg    = (dif_x == '0) && (dif_y == '0);
            end
            v2fa_pkg::KIND_DIV:
            begin
                job.deg = (cmd.scalar == '0);
            end
            v2fa_pkg::KIND_NORM:
            begin
                job.deg = (cmd.a_x == '0) && (cmd.a_y == '0);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/v2fa_queue.sv =====
`timescale 1ns / 1ps
module v2fa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  v2fa_pkg::job_t   wr_job,
    input  logic             pop,
    output v2fa_pkg::job_t   head,
    output logic             head_valid,
    output v2fa_pkg::qstat_t stat
);

    localparam int DEPTH = v2fa_pkg::QUEUE_DEPTH;
    localparam int CW    = v2fa_pkg::QCNT_WIDTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    v2fa_pkg::job_t slot_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CW-1:0]   count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/v2fa_back.sv =====
`timescale 1ns / 1ps
module v2fa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  v2fa_pkg::job_t head,
    input  logic           head_valid,
    output logic           pop,
    output v2fa_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    localparam int W  = v2fa_pkg::COORD_WIDTH;
    localparam int F  = v2fa_pkg::FRAC_BITS;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 4;
    localparam int RW = 2 * W;
    localparam int DN = W + F;

    localparam logic [W-1:0]  VMAX = v2fa_pkg::VAL_MAX;
    localparam logic [W-1:0]  VMIN = v2fa_pkg::VAL_MIN;
    localparam logic [W-1:0]  NEG1 = v2fa_pkg::NEG_ONE_FIX;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

    typedef struct packed {
        v2fa_pkg::kind_t op;
        logic            deg;
        logic            ovf;
        logic            fixed;   // result already settled
        logic [W-1:0]    res_x;
        logic [W-1:0]    res_y;
        logic            neg_x;
        logic            neg_y;
        logic [W-1:0]    num_x;
        logic [W-1:0]    num_y;
        logic [W-1:0]    sdiv;
    } ctx_t;

    typedef struct packed {
        v2fa_pkg::kind_t op;
        logic            deg;
        logic            ovf;
        logic [W-1:0]    res_x;
        logic [W-1:0]    res_y;
        logic [PW-1:0]   prod_x;
        logic [PW-1:0]   prod_y;
        logic [W:0]      mag_x;
        logic [W:0]      mag_y;
        logic            neg_x;
        logic            neg_y;
        logic            sneg;
        logic [W-1:0]    base_x;
        logic [W-1:0]    base_y;
        logic [W-1:0]    sdiv;
    } mst_t;

    typedef struct packed {
        ctx_t         ctx;
        logic [RW-1:0] rad;
        logic [W+1:0]  rem;
        logic [W-1:0]  root;
    } sqs_t;

    typedef struct packed {
        ctx_t          ctx;
        logic [W-1:0]  d;
        logic [DN-1:0] nx;
        logic [DN-1:0] ny;
        logic [DN-1:0] qx;
        logic [DN-1:0] qy;
        logic [W-1:0]  rx;
        logic [W-1:0]  ry;
    } dvs_t;

    function automatic logic [W:0] sat_add(input logic [W:0] v);
        if (v[W] != v[W-1])
        begin
            return v[W] ? {1'b1, VMIN} : {1'b1, VMAX};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] v);
        if (v > $signed({{(SW-W){1'b0}}, VMAX}))
        begin
            return {1'b1, VMAX};
        end
        if (v < $signed({{(SW-W){1'b1}}, VMIN}))
        begin
            return {1'b1, VMIN};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_quot(input logic [DN-1:0] q, input logic neg);
        logic [DN-1:0] nq;
        nq = ~q + 1'b1;
        if (neg)
        begin
            if (q > DN'(VMIN))
            begin
                return {1'b1, VMIN};
            end
            return {1'b0, nq[W-1:0]};
        end
        if (q > DN'(VMAX))
        begin
            return {1'b1, VMAX};
        end
        return {1'b0, q[W-1:0]};
    endfunction

    // whole pipe moves together; holds only while a result waits
    logic en;
    logic rsp_valid_reg;
    v2fa_pkg::rsp_t rsp_reg;
    v2fa_pkg::rsp_t rsp_next;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign pop       = en && head_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // multiply stage
    mst_t m_reg;
    mst_t m_next;
    logic m_valid_reg;
    logic [W:0] sc_ext;
    logic [W:0] smag;
    logic [W:0] mag_x;
    logic [W:0] mag_y;
    logic [W:0] fac_x;
    logic [W:0] fac_y;
    logic [W:0] sx_pat;
    logic [W:0] sy_pat;
    logic       squares;

    always_comb
    begin
        sc_ext  = {head.scalar[W-1], head.scalar};
        smag    = sc_ext[W] ? (~sc_ext + 1'b1) : sc_ext;
        mag_x   = head.opnd_x[W] ? (~head.opnd_x + 1'b1) : head.opnd_x;
        mag_y   = head.opnd_y[W] ? (~head.opnd_y + 1'b1) : head.opnd_y;
        squares = (head.op == v2fa_pkg::KIND_DIST) || (head.op == v2fa_pkg::KIND_NORM);
        fac_x   = squares ? mag_x : smag;
        fac_y   = squares ? mag_y : smag;
        sx_pat  = sat_add(head.opnd_x);
        sy_pat  = sat_add(head.opnd_y);

        m_next.op     = head.op;
        m_next.deg    = head.deg;
        m_next.ovf    = sx_pat[W] || sy_pat[W];
        m_next.res_x  = sx_pat[W-1:0];
        m_next.res_y  = sy_pat[W-1:0];
        m_next.prod_x = PW'(mag_x) * PW'(fac_x);
        m_next.prod_y = PW'(mag_y) * PW'(fac_y);
        m_next.mag_x  = mag_x;
        m_next.mag_y  = mag_y;
        m_next.neg_x  = head.opnd_x[W];
        m_next.neg_y  = head.opnd_y[W];
        m_next.sneg   = head.scalar[W-1];
        m_next.base_x = head.base_x;
        m_next.base_y = head.base_y;
        m_next.sdiv   = smag[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    // round / saturate stage, feeds the root pipe
    sqs_t sq_reg [W+1];
    logic sq_valid_reg [W+1];
    sqs_t sq_next;
    logic [PW-1:0]        rnd_x;
    logic [PW-1:0]        rnd_y;
    logic signed [SW-1:0] v_x;
    logic signed [SW-1:0] v_y;
    logic [W:0]           sl_x;
    logic [W:0]           sl_y;
    logic                 big;

    always_comb
    begin
        rnd_x = (m_reg.prod_x + HALF) >> F;
        rnd_y = (m_reg.prod_y + HALF) >> F;
        v_x   = $signed(SW'(rnd_x));
        v_y   = $signed(SW'(rnd_y));
        if (m_reg.neg_x ^ m_reg.sneg)
        begin
            v_x = -v_x;
        end
        if (m_reg.neg_y ^ m_reg.sneg)
        begin
            v_y = -v_y;
        end
        if (m_reg.op == v2fa_pkg::KIND_LERP)
        begin
            v_x = v_x + SW'($signed(m_reg.base_x));
            v_y = v_y + SW'($signed(m_reg.base_y));
        end
        sl_x = sat_wide(v_x);
        sl_y = sat_wide(v_y);
        big  = (m_reg.mag_x[W:W-1] != 2'b00) || (m_reg.mag_y[W:W-1] != 2'b00);

        sq_next.ctx.op    = m_reg.op;
        sq_next.ctx.deg   = m_reg.deg;
        sq_next.ctx.ovf   = 1'b0;
        sq_next.ctx.fixed = 1'b0;
        sq_next.ctx.res_x = '0;
        sq_next.ctx.res_y = '0;
        sq_next.ctx.neg_x = m_reg.neg_x;
        sq_next.ctx.neg_y = m_reg.neg_y;
        sq_next.ctx.num_x = m_reg.mag_x[W-1:0];
        sq_next.ctx.num_y = m_reg.mag_y[W-1:0];
        sq_next.ctx.sdiv  = m_reg.sdiv;
        sq_next.rad       = RW'(m_reg.prod_x + m_reg.prod_y);
        sq_next.rem       = '0;
        sq_next.root      = '0;
        case (m_reg.op)
            v2fa_pkg::KIND_ADD, v2fa_pkg::KIND_SUB:
            begin
                sq_next.ctx.res_x = m_reg.res_x;
                sq_next.ctx.res_y = m_reg.res_y;
                sq_next.ctx.ovf   = m_reg.ovf;
            end
            v2fa_pkg::KIND_SCALE, v2fa_pkg::KIND_LERP:
            begin
                sq_next.ctx.res_x = sl_x[W-1:0];
                sq_next.ctx.res_y = sl_y[W-1:0];
                sq_next.ctx.ovf   = sl_x[W] || sl_y[W];
            end
            v2fa_pkg::KIND_DIV:
            begin
                sq_next.ctx.neg_x = m_reg.neg_x ^ m_reg.sneg;
                sq_next.ctx.neg_y = m_reg.neg_y ^ m_reg.sneg;
            end
            v2fa_pkg::KIND_DIST:
            begin
                if (m_reg.deg)
                begin
                    sq_next.ctx.res_x = NEG1;
                    sq_next.ctx.fixed = 1'b1;
                end
                else if (big)
                begin
                    sq_next.ctx.res_x = VMAX;
                    sq_next.ctx.ovf   = 1'b1;
                    sq_next.ctx.fixed = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq_next;
        end
    end

    // square root: one root bit per stage
    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        sqs_t step_next;
        logic [W+3:0] rem_sh;
        logic [W+3:0] trial;

        always_comb
        begin
            step_next = sq_reg[i];
            rem_sh    = {sq_reg[i].rem, sq_reg[i].rad[2*(W-1-i)+1 -: 2]};
            trial     = {2'b00, sq_reg[i].root, 2'b01};
            if (rem_sh >= trial)
            begin
                step_next.rem  = (W+2)'(rem_sh - trial);
                step_next.root = {sq_reg[i].root[W-2:0], 1'b1};
            end
            else
            begin
                step_next.rem  = (W+2)'(rem_sh);
                step_next.root = {sq_reg[i].root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[i+1] <= step_next;
            end
        end
    end

    // root rounding, divisor and dividend setup
    dvs_t dv_reg [DN+1];
    logic dv_valid_reg [DN+1];
    dvs_t dv_next;
    logic [W-1:0] root_r;

    always_comb
    begin
        root_r  = sq_reg[W].root
                + W'(sq_reg[W].rem > (W+2)'(sq_reg[W].root));
        dv_next.ctx = sq_reg[W].ctx;
        if ((sq_reg[W].ctx.op == v2fa_pkg::KIND_DIST) && !sq_reg[W].ctx.fixed)
        begin
            dv_next.ctx.res_x = (root_r > VMAX) ? VMAX : root_r;
            dv_next.ctx.ovf   = (root_r > VMAX);
        end
        dv_next.d  = (sq_reg[W].ctx.op == v2fa_pkg::KIND_NORM) ? root_r : sq_reg[W].ctx.sdiv;
        dv_next.nx = (DN'(sq_reg[W].ctx.num_x) << F) + DN'(dv_next.d >> 1);
        dv_next.ny = (DN'(sq_reg[W].ctx.num_y) << F) + DN'(dv_next.d >> 1);
        dv_next.qx = '0;
        dv_next.qy = '0;
        dv_next.rx = '0;
        dv_next.ry = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv_next;
        end
    end

    // restoring division, both lanes, one quotient bit per stage
    for (genvar j = 0; j < DN; j++)
    begin : g_div
        dvs_t step_next;
        logic [W:0] r2x;
        logic [W:0] r2y;

        always_comb
        begin
            step_next = dv_reg[j];
            r2x = {dv_reg[j].rx, dv_reg[j].nx[DN-1-j]};
            r2y = {dv_reg[j].ry, dv_reg[j].ny[DN-1-j]};
            if (r2x >= {1'b0, dv_reg[j].d})
            begin
                step_next.rx         = W'(r2x - {1'b0, dv_reg[j].d});
                step_next.qx[DN-1-j] = 1'b1;
            end
            else
            begin
                step_next.rx = r2x[W-1:0];
            end
            if (r2y >= {1'b0, dv_reg[j].d})
            begin
                step_next.ry         = W'(r2y - {1'b0, dv_reg[j].d});
                step_next.qy[DN-1-j] = 1'b1;
            end
            else
            begin
                step_next.ry = r2y[W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1] <= step_next;
            end
        end
    end

    // result select into the output register
    logic [W:0] qs_x;
    logic [W:0] qs_y;

    always_comb
    begin
        qs_x     = sat_quot(dv_reg[DN].qx, dv_reg[DN].ctx.neg_x);
        qs_y     = sat_quot(dv_reg[DN].qy, dv_reg[DN].ctx.neg_y);
        rsp_next = '0;
        case (dv_reg[DN].ctx.op)
            v2fa_pkg::KIND_ADD, v2fa_pkg::KIND_SUB, v2fa_pkg::KIND_SCALE,
            v2fa_pkg::KIND_LERP, v2fa_pkg::KIND_DIST:
            begin
                rsp_next.result_x   = dv_reg[DN].ctx.res_x;
                rsp_next.result_y   = dv_reg[DN].ctx.res_y;
                rsp_next.degenerate = dv_reg[DN].ctx.deg;
                rsp_next.overflow   = dv_reg[DN].ctx.ovf;
            end
            v2fa_pkg::KIND_DIV, v2fa_pkg::KIND_NORM:
            begin
                if (dv_reg[DN].ctx.deg)
                begin
                    rsp_next.result_x   = NEG1;
                    rsp_next.result_y   = NEG1;
                    rsp_next.degenerate = 1'b1;
                end
                else
                begin
                    rsp_next.result_x = qs_x[W-1:0];
                    rsp_next.result_y = qs_y[W-1:0];
                    rsp_next.overflow = qs_x[W] || qs_y[W];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= dv_valid_reg[DN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== rtl/core/vector2_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// channel  | valid     | stall     | payload        | item
// ---------+-----------+-----------+----------------+-------------------------------
// command  | cmd_valid | cmd_stall | cmd (cmd_t)    | opcode, vectors A and B, scalar
// response | rsp_valid | rsp_stall | rsp (rsp_t)    | result vector and flags
//
// One item enters per cycle while cmd_stall is low (queue not full). Each item's path
// from acceptance to its Q16.16 result includes the one-bit-per-stage
// square-root pipe (COORD_WIDTH stages) followed by the divider pipe
// (COORD_WIDTH + FRAC_BITS stages). rst_n clears all valid bits and the queue.
// A stalled result freezes the back pipe; the front keeps taking items until
// the queue between them is full.
module vector2_fixed_point_alu_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  v2fa_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output v2fa_pkg::rsp_t rsp
);

    v2fa_pkg::qstat_t q_stat;
    v2fa_pkg::job_t   wr_job;
    v2fa_pkg::job_t   head;
    logic             push;
    logic             pop;
    logic             head_valid;

    // front: classifies opcode, forms sums/differences, flags zero divisors and zero distances
    v2fa_front u_front (
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .q_stat    (q_stat),
        .push      (push),
        .job       (wr_job)
    );

    // short queue decouples the front from the back pipe
    v2fa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (wr_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .stat       (q_stat)
    );

    // back: multiply, round, square root, divide, saturate, output register
    v2fa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall)
    );

    // queue fill moves by at most one item per cycle
    a_qcount_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.count == $past(q_stat.count)) ||
        (q_stat.count == $past(q_stat.count) + 1'b1) ||
        (q_stat.count + 1'b1 == $past(q_stat.count)))
        else $error("queue count jumped");

    // fallback result is always -1.0 in x
    a_deg_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.degenerate) |-> (rsp.result_x == v2fa_pkg::NEG_ONE_FIX))
        else $error("degenerate result without fallback value");

    // a fallback never saturates
    a_deg_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.degenerate) |-> !rsp.overflow)
        else $error("degenerate and overflow together");

endmodule

// ===== tb/tb_vector2_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
import v2fa_pkg::*;

// Tracks the results still owed by the ALU and checks each one as it leaves.
class result_tracker;
    rsp_t expected_results[$];
    int   errors;
    bit   ov_hit;

    function new();
        errors = 0;
    endfunction

    task report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
    endfunction

    function longint signed_of(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            ov_hit = 1;
            return hi;
        end
        if (v < lo)
        begin
            ov_hit = 1;
            return lo;
        end
        return v;
    endfunction

    // fixed-point product, nearest with ties away from zero
    function longint fx_mul(longint p, longint q);
        longint unsigned m;
        m = magnitude(p) * magnitude(q);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return signed_of(m, (p < 0) != (q < 0));
    endfunction

    function longint fx_div(longint n, longint d);
        longint unsigned dm;
        longint unsigned nm;
        longint unsigned q;
        dm = magnitude(d);
        nm = magnitude(n) << FRAC_BITS;
        q  = (nm + dm / 2) / dm;
        return signed_of(q, (n < 0) != (d < 0));
    endfunction

    function longint unsigned root_nearest(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (v > r)
            r++;
        return r;
    endfunction

    function rsp_t compute_result(cmd_t c);
        rsp_t           r;
        longint         ax, ay, bx, by, s, rx, ry, len, one;
        longint unsigned dx, dy;
        bit             deg;
        ax = c.a_x;
        ay = c.a_y;
        bx = c.b_x;
        by = c.b_y;
        s  = c.scalar;
        rx = 0;
        ry = 0;
        deg = 0;
        ov_hit = 0;
        one = longint'(1) <<< FRAC_BITS;
        case (c.kind)
            KIND_ADD:
            begin
                rx = clamp(ax + bx);
                ry = clamp(ay + by);
            end
            KIND_SUB:
            begin
                rx = clamp(bx - ax);
                ry = clamp(by - ay);
            end
            KIND_DIV:
            begin
                if (s == 0)
                begin
                    rx = -one;
                    ry = -one;
                    deg = 1;
                end
                else
                begin
                    rx = clamp(fx_div(ax, s));
                    ry = clamp(fx_div(ay, s));
                end
            end
            KIND_SCALE:
            begin
                rx = clamp(fx_mul(ax, s));
                ry = clamp(fx_mul(ay, s));
            end
            KIND_LERP:
            begin
                rx = clamp(ax + fx_mul(bx - ax, s));
                ry = clamp(ay + fx_mul(by - ay, s));
            end
            KIND_DIST:
            begin
                dx = magnitude(bx - ax);
                dy = magnitude(by - ay);
                if (dx == 0 && dy == 0)
                begin
                    rx = -one;
                    deg = 1;
                end
                else if (dx >= (64'd1 << (COORD_WIDTH - 1)) ||
                         dy >= (64'd1 << (COORD_WIDTH - 1)))
                begin
                    rx = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
                    ov_hit = 1;
                end
                else
                    rx = clamp(longint'(root_nearest(dx * dx + dy * dy)));
            end
            KIND_NORM:
            begin
                dx = magnitude(ax);
                dy = magnitude(ay);
                if (dx == 0 && dy == 0)
                begin
                    rx = -one;
                    ry = -one;
                    deg = 1;
                end
                else
                begin
                    len = longint'(root_nearest(dx * dx + dy * dy));
                    rx = clamp(fx_div(ax, len));
                    ry = clamp(fx_div(ay, len));
                end
            end
            default:
            begin
            end
        endcase
        r.result_x   = rx[COORD_WIDTH-1:0];
        r.result_y   = ry[COORD_WIDTH-1:0];
        r.degenerate = deg;
        r.overflow   = ov_hit;
        return r;
    endfunction

    function void note_command(cmd_t c);
        expected_results.push_back(compute_result(c));
    endfunction

    task check_result(rsp_t got);
        rsp_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.result_x !== want.result_x)
            report($sformatf("result_x got %h want %h", got.result_x, want.result_x));
        if (got.result_y !== want.result_y)
            report($sformatf("result_y got %h want %h", got.result_y, want.result_y));
        if (got.degenerate !== want.degenerate)
            report($sformatf("degenerate got %b want %b", got.degenerate, want.degenerate));
        if (got.overflow !== want.overflow)
            report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
    endtask
endclass

module tb_vector2_fixed_point_alu_unit;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    result_tracker tracker;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_HALF = 32'h0000_8000;

    vector2_fixed_point_alu_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Result side: one process owns rsp_stall (changed on falling edges),
    // checking happens on rising edges.
    initial
    begin
        int span;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        // normal random back-pressure for a while
        repeat (300)
        begin
            span = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            @(negedge clk);
            if (span != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (span) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(20, 60);
            repeat (span) @(negedge clk);
        end
        // long hold-off: back pipe freezes and the queue fills, command side must stall
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (400) @(negedge clk);
        rsp_stall <= 1'b0;
        forever
        begin
            span = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            @(negedge clk);
            if (span != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (span) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(20, 60);
            repeat (span) @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_result(rsp);

    // Offer one item; valid stays high until accepted.
    task send_item(cmd_t c);
        @(negedge clk);
        cmd       <= c;
        cmd_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!cmd_stall)
                break;
        end
        tracker.note_command(c);
    endtask

    // Optional idle cycles after an item; no gap keeps valid high.
    task idle_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        else if ($urandom_range(0, 9) < 8)
            gap = $urandom_range(0, 3);
        else
            gap = $urandom_range(10, 50);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
            4: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            5: return 32'($signed($urandom_range(0, 511)) - 256);
            default: return $urandom;
        endcase
    endfunction

    function cmd_t random_item();
        cmd_t c;
        c.kind   = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        c.a_x    = pick_value();
        c.a_y    = pick_value();
        c.b_x    = pick_value();
        c.b_y    = pick_value();
        c.scalar = pick_value();
        case ($urandom_range(0, 7))
            0:
            begin
                // coincident points: zero distance
                c.b_x = c.a_x;
                c.b_y = c.a_y;
            end
            1:
            begin
                c.a_x = '0;
                c.a_y = '0;
            end
            2: c.scalar = '0;
            3: c.scalar = $urandom_range(0, Q_ONE); // lerp fraction in [0,1]
            default:
            begin
            end
        endcase
        return c;
    endfunction

    function cmd_t make_item(kind_t k, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] s);
        cmd_t c;
        c.kind   = k;
        c.a_x    = ax;
        c.a_y    = ay;
        c.b_x    = bx;
        c.b_y    = by;
        c.scalar = s;
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        tracker   = new();
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: each opcode, extremes, the degenerate and saturating cases
        send_item(make_item(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_item(make_item(KIND_ADD, Q_ONE, -Q_ONE, Q_HALF, Q_HALF, 0));
        send_item(make_item(KIND_SUB, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_item(make_item(KIND_SUB, Q_ONE, Q_ONE, 3 * Q_ONE, -Q_ONE, 0));
        send_item(make_item(KIND_DIV, Q_ONE, -Q_ONE, 0, 0, 0));
        send_item(make_item(KIND_DIV, 3 * Q_ONE, -5 * Q_ONE, 0, 0, 2 * Q_ONE));
        send_item(make_item(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1));
        send_item(make_item(KIND_DIV, 32'h8000_0000, 1, 0, 0, 32'h8000_0000));
        send_item(make_item(KIND_DIV, 1, -1, 0, 0, 3));
        send_item(make_item(KIND_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000));
        send_item(make_item(KIND_SCALE, 1, -1, 0, 0, Q_HALF));
        send_item(make_item(KIND_SCALE, 3, -3, 0, 0, Q_HALF));
        send_item(make_item(KIND_LERP, 32'h8000_0000, 0, 32'h7FFF_FFFF, Q_ONE, 32'h7FFF_FFFF));
        send_item(make_item(KIND_LERP, 0, Q_ONE, 4 * Q_ONE, -Q_ONE, Q_HALF));
        send_item(make_item(KIND_DIST, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0));
        send_item(make_item(KIND_DIST, 0, 0, 3 * Q_ONE, 4 * Q_ONE, 0));
        send_item(make_item(KIND_DIST, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0));
        send_item(make_item(KIND_DIST, 0, 32'h8000_0000, 0, 0, 0));
        send_item(make_item(KIND_DIST, 32'hC000_0000, 32'hC000_0000,
                            32'h3FFF_FFFF, 32'h3FFF_FFFF, 0));
        send_item(make_item(KIND_NORM, 0, 0, Q_ONE, Q_ONE, Q_ONE));
        send_item(make_item(KIND_NORM, 3 * Q_ONE, -4 * Q_ONE, 0, 0, 0));
        send_item(make_item(KIND_NORM, 1, 0, 0, 0, 0));
        send_item(make_item(KIND_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        c = make_item(KIND_ADD, -1, -1, -1, -1, -1);
        c.kind = 3'd7;
        send_item(c);

        repeat (1600)
        begin
            idle_gap();
            send_item(random_item());
        end
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (200) @(posedge clk);

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #6ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/v2fa_pkg.sv
rtl/core/v2fa_front.sv
rtl/core/v2fa_queue.sv
rtl/core/v2fa_back.sv
rtl/core/vector2_fixed_point_alu_unit.sv
tb/tb_vector2_fixed_point_alu_unit.sv
